// ===== design/cpm_pkg.sv =====
// ----------------------------------------------------------------------------
// cpm_pkg: shared types for the close point merge unit
// Transaction payloads, cell control and controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none
package cpm_pkg;

   localparam int COORD_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_DIST_THRESHOLD = 1'b0;
   localparam logic [COORD_W-1:0] DIST_THRESHOLD_RESET = 16'd320;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } point_type;

   typedef struct packed {
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               last_out;
      logic               overflowed;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic rotate;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_TSQ,
      ST_POP,
      ST_SQ,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

// ===== design/cpm_cell.sv =====
// ----------------------------------------------------------------------------
// cpm_cell: one point slot of the point chain
// Loads, shifts toward the head, or rotates the head value into the tail.
// ----------------------------------------------------------------------------
`default_nettype none
module cpm_cell (
   input  wire                         clock,
   input  wire cpm_pkg::cell_ctrl_type ctrl,
   input  wire                         sel_load,
   input  wire                         at_tail,
   input  wire                         before_tail,
   input  wire cpm_pkg::point_type     load_data,
   input  wire cpm_pkg::point_type     neighbor_data,
   input  wire cpm_pkg::point_type     head_data,
   output cpm_pkg::point_type          data
);

   cpm_pkg::point_type data_ff;
   cpm_pkg::point_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load && sel_load) begin
         data_in = load_data;
      end else if (ctrl.shift) begin
         data_in = neighbor_data;
      end else if (ctrl.rotate) begin
         if (at_tail) begin
            data_in = head_data;
         end else if (before_tail) begin
            data_in = neighbor_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
`default_nettype wire

// ===== design/close_point_merge_unit.sv =====
// ----------------------------------------------------------------------------
// close_point_merge_unit: merges detected 2-D points that lie close together
// Points load into a chain of cells; the merge pass pops the head point and
// rotates the rest of the chain past a squared-distance comparator.
// ----------------------------------------------------------------------------
// Points load while the unit is idle; after the last point, the pass squares
// the threshold, then pops each stored point and, per rotation, squares its
// distance to the head and compares it, emitting each surviving point once
// any output stall clears. One list is processed at a time.
// Synchronous reset clears control state and sets the threshold to 320;
// the point cells are not reset.
`default_nettype none
module close_point_merge_unit #(
   parameter int MAX_POINTS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire cpm_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output cpm_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [cpm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire  [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int CW_FULL = CW;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

   cpm_pkg::state_type state_ff, state_in;
   logic [15:0] thr_ff;
   logic [31:0] tsq_ff;
   logic [CW_FULL-1:0] cnt_ff, cnt_in;
   logic [CW_FULL-1:0] rot_ff, rot_in;
   logic ovf_ff, ovf_in;
   logic merged_ff, merged_in;
   cpm_pkg::point_type cur_ff;
   logic [31:0] sqx_ff, sqy_ff;
   logic rsp_valid_ff;
   cpm_pkg::rsp_type rsp_ff;

   cpm_pkg::cell_ctrl_type ctrl;
   cpm_pkg::point_type cell_q [MAX_POINTS];
   cpm_pkg::point_type load_pt, head_pt, mid_pt;
   logic req_fire, emit_go, close;
   logic [15:0] dx, dy;
   logic [32:0] d2;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == cpm_pkg::REG_DIST_THRESHOLD) ? {16'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cpm_pkg::DIST_THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == cpm_pkg::REG_DIST_THRESHOLD) begin
         thr_ff <= csr_pwdata[15:0];
      end
   end

   assign req_ready = (state_ff == cpm_pkg::ST_LOAD);
   assign req_fire = req_valid && req_ready;
   assign load_pt.x = req_data.point_x;
   assign load_pt.y = req_data.point_y;

   assign dx = (cur_ff.x > cell_q[0].x) ? cur_ff.x - cell_q[0].x : cell_q[0].x - cur_ff.x;
   assign dy = (cur_ff.y > cell_q[0].y) ? cur_ff.y - cell_q[0].y : cell_q[0].y - cur_ff.y;
   assign d2 = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign close = !merged_ff && (d2 < {1'b0, tsq_ff});
   assign mid_pt.x = 16'(({1'b0, cur_ff.x} + {1'b0, cell_q[0].x}) >> 1);
   assign mid_pt.y = 16'(({1'b0, cur_ff.y} + {1'b0, cell_q[0].y}) >> 1);
   assign head_pt = close ? mid_pt : cell_q[0];
   assign emit_go = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rot_in = rot_ff;
      ovf_in = ovf_ff;
      merged_in = merged_ff;
      ctrl = '0;
      case (state_ff)
         cpm_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (cnt_ff < CNT_MAX) begin
                  ctrl.load = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_point) begin
                  state_in = cpm_pkg::ST_TSQ;
               end
            end
         end
         cpm_pkg::ST_TSQ: begin
            state_in = cpm_pkg::ST_POP;
         end
         cpm_pkg::ST_POP: begin
            merged_in = 1'b0;
            if (cnt_ff == '0) begin
               ovf_in = 1'b0;
               state_in = cpm_pkg::ST_LOAD;
            end else begin
               ctrl.shift = 1'b1;
               cnt_in = cnt_ff - 1'b1;
               rot_in = cnt_ff - 1'b1;
               state_in = (cnt_ff == CW'(1)) ? cpm_pkg::ST_EMIT : cpm_pkg::ST_SQ;
            end
         end
         cpm_pkg::ST_SQ: begin
            state_in = cpm_pkg::ST_CMP;
         end
         cpm_pkg::ST_CMP: begin
            ctrl.rotate = 1'b1;
            merged_in = merged_ff || close;
            rot_in = rot_ff - 1'b1;
            if (rot_ff == CW'(1)) begin
               state_in = (merged_ff || close) ? cpm_pkg::ST_POP : cpm_pkg::ST_EMIT;
            end else begin
               state_in = cpm_pkg::ST_SQ;
            end
         end
         cpm_pkg::ST_EMIT: begin
            if (emit_go) begin
               state_in = cpm_pkg::ST_POP;
            end
         end
         default: begin
            state_in = cpm_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpm_pkg::ST_LOAD;
         cnt_ff <= '0;
         rot_ff <= '0;
         ovf_ff <= 1'b0;
         merged_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rot_ff <= rot_in;
         ovf_ff <= ovf_in;
         merged_ff <= merged_in;
         if (state_ff == cpm_pkg::ST_EMIT && emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cpm_pkg::ST_TSQ) begin
         tsq_ff <= 32'(thr_ff) * 32'(thr_ff);
      end
      if (state_ff == cpm_pkg::ST_POP) begin
         cur_ff <= cell_q[0];
      end
      sqx_ff <= 32'(dx) * 32'(dx);
      sqy_ff <= 32'(dy) * 32'(dy);
      if (state_ff == cpm_pkg::ST_EMIT && emit_go) begin
         rsp_ff.out_x <= cur_ff.x;
         rsp_ff.out_y <= cur_ff.y;
         rsp_ff.last_out <= (cnt_ff == '0);
         rsp_ff.overflowed <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
      cpm_pkg::point_type nb;
      if (k == MAX_POINTS - 1) begin : g_end
         assign nb = '0;
      end else begin : g_mid
         assign nb = cell_q[k+1];
      end
      cpm_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .sel_load      (cnt_ff == CW'(k)),
         .at_tail       ({1'b0, cnt_ff} == CW'(k) + (CW+1)'(1)),
         .before_tail   ({1'b0, cnt_ff} > CW'(k) + (CW+1)'(1)),
         .load_data     (load_pt),
         .neighbor_data (nb),
         .head_data     (head_pt),
         .data          (cell_q[k])
      );
   end

endmodule
`default_nettype wire
